// ===== src/qalu_pkg.sv =====
package qalu_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int DATA_W = 32;

    typedef enum logic [3:0] {
        K_ADD  = 4'd0,
        K_SUB  = 4'd1,
        K_MUL  = 4'd2,
        K_DIV  = 4'd3,
        K_MIN  = 4'd4,
        K_MAX  = 4'd5,
        K_INC  = 4'd6,
        K_DEC  = 4'd7,
        K_FROM = 4'd8,
        K_TOI  = 4'd9
    } t_kind;

    typedef struct packed {
        logic [3:0]         kind;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_in;

    typedef struct packed {
        logic signed [31:0] result;
        logic               a_less;
        logic               a_equal;
        logic               a_greater;
        logic               div_by_zero;
    } t_out;

    // Control that travels beside the divider's data.
    typedef struct packed {
        logic        vld;
        logic [3:0]  kind;
        logic [31:0] simple;
        logic        lt;
        logic        eq;
        logic        gt;
        logic        dz;
        logic        neg;
    } t_ctl;

endpackage

// ===== src/qalu_mul.sv =====
// Pipelined signed multiplier: 32x32 cut into four 16x16 partial products,
// then summed and scaled with truncation toward zero.
module qalu_mul #(
    parameter int FRAC_BITS = qalu_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_p
);
    logic        r_neg1, r_neg2;
    logic [15:0] r_al, r_ah, r_bl, r_bh;
    logic [31:0] r_ll, r_lh, r_hl, r_hh;
    logic [63:0] r_mag;
    logic [31:0] a_mag, b_mag;
    logic [63:0] n_mag;
    logic [63:0] shifted;

    // Stage 1: magnitudes.
    always_comb begin
        a_mag = i_a[31] ? (~i_a + 32'd1) : i_a;
        b_mag = i_b[31] ? (~i_b + 32'd1) : i_b;
    end

    always_ff @(posedge i_clk) begin
        r_neg1 <= i_a[31] ^ i_b[31];
        r_al <= a_mag[15:0];
        r_ah <= a_mag[31:16];
        r_bl <= b_mag[15:0];
        r_bh <= b_mag[31:16];
    end

    // Stage 2: partial products.
    always_ff @(posedge i_clk) begin
        r_neg2 <= r_neg1;
        r_ll <= r_al * r_bl;
        r_lh <= r_al * r_bh;
        r_hl <= r_ah * r_bl;
        r_hh <= r_ah * r_bh;
    end

    // Stage 3: sum and truncate the magnitude, then restore the sign.
    always_comb begin
        n_mag = {r_hh, 32'd0} + {16'd0, r_lh, 16'd0} + {16'd0, r_hl, 16'd0}
              + {32'd0, r_ll};
        shifted = n_mag >> FRAC_BITS;
        if (r_neg2) begin
            shifted = ~shifted + 64'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= shifted;
    end

    assign o_p = r_mag[31:0];
endmodule

// ===== src/qalu_div.sv =====
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// Dividend is |a| << FRAC_BITS (32+FRAC_BITS bits), divisor |b|.
// Stages: input register, one per quotient bit, then the sign fix; QW = 32 + FRAC_BITS.
module qalu_div #(
    parameter int FRAC_BITS = qalu_pkg::FRAC_BITS_DEF,
    localparam int QW = 32 + FRAC_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  qalu_pkg::t_ctl i_ctl,
    input  logic [31:0]    i_a,
    input  logic [31:0]    i_b,
    output qalu_pkg::t_ctl o_ctl,
    output logic [31:0]    o_q
);
    qalu_pkg::t_ctl r_ctl [QW+1];
    logic [QW-1:0]  r_num [QW+1];
    logic [31:0]    r_den [QW+1];
    logic [32:0]    r_rem [QW+1];
    logic [31:0]    r_q;
    logic [31:0]    a_mag, b_mag;

    always_comb begin
        a_mag = i_a[31] ? (~i_a + 32'd1) : i_a;
        b_mag = i_b[31] ? (~i_b + 32'd1) : i_b;
    end

    // Stage 0: register magnitudes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0].vld <= 1'b0;
        end else begin
            r_ctl[0] <= i_ctl;
        end
        r_num[0] <= {a_mag, {FRAC_BITS{1'b0}}};
        r_den[0] <= b_mag;
        r_rem[0] <= '0;
    end

    // One quotient bit per stage; quotient bits replace dividend bits.
    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [32:0] trial;
        logic [33:0] diff;
        always_comb begin
            trial = {r_rem[s][31:0], r_num[s][QW-1]};
            diff  = {1'b0, trial} - {2'b00, r_den[s]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[s+1].vld <= 1'b0;
            end else begin
                r_ctl[s+1] <= r_ctl[s];
            end
            r_den[s+1] <= r_den[s];
            if (!diff[33]) begin
                r_rem[s+1] <= diff[32:0];
                r_num[s+1] <= {r_num[s][QW-2:0], 1'b1};
            end else begin
                r_rem[s+1] <= trial;
                r_num[s+1] <= {r_num[s][QW-2:0], 1'b0};
            end
        end
    end

    // Final sign fix.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl.vld <= 1'b0;
        end else begin
            o_ctl <= r_ctl[QW];
        end
        r_q <= r_ctl[QW].neg ? (~r_num[QW][31:0] + 32'd1) : r_num[QW][31:0];
    end

    assign o_q = r_q;
endmodule

// ===== src/q24_8_fixed_point_alu.sv =====
// Q24.8 fixed-point ALU.
// Issue an item by raising i_start with i_in (kind, operand_a, operand_b);
// o_busy is always low, so an item is taken on every cycle that i_start
// is high. Each item yields exactly one result on o_out, marked by a
// one-cycle o_done strobe; results leave in issue order.
// Every kind shares one pipeline whose length is set by the divider:
// one input stage, then one stage per quotient bit (32 + FRAC_BITS),
// then a sign stage and the output register from which the result is
// taken; the throughput is one item per cycle.
// The multiplier (3 stages) runs beside the first divider stages and its
// product is picked up by a delay line so all kinds leave together.
// Synchronous reset clears all valid bits; items in flight are dropped.
// The receiver cannot stall, so no back pressure exists.
module q24_8_fixed_point_alu #(
    parameter int FRAC_BITS = qalu_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  qalu_pkg::t_in  i_in,
    output logic           o_busy,
    output logic           o_done,
    output qalu_pkg::t_out o_out
);
    localparam int QW  = 32 + FRAC_BITS;
    localparam int DLY = QW + 2 - 3;

    qalu_pkg::t_ctl n_ctl, div_ctl;
    logic [31:0]    div_q, mul_p;
    logic [31:0]    r_mdly [DLY];
    logic [31:0]    n_res;
    qalu_pkg::t_out r_out;
    logic           r_done;
    logic signed [31:0] a, b;

    assign o_busy = 1'b0;
    assign a = i_in.operand_a;
    assign b = i_in.operand_b;

    // Simple kinds and flags are worked out on entry.
    always_comb begin
        n_ctl.vld  = i_start;
        n_ctl.kind = i_in.kind;
        n_ctl.lt   = a < b;
        n_ctl.eq   = a == b;
        n_ctl.gt   = a > b;
        n_ctl.dz   = (i_in.kind == qalu_pkg::K_DIV) && (b == 32'sd0);
        n_ctl.neg  = a[31] ^ b[31];
        unique case (i_in.kind)
            qalu_pkg::K_ADD:  n_ctl.simple = a + b;
            qalu_pkg::K_SUB:  n_ctl.simple = a - b;
            qalu_pkg::K_MIN:  n_ctl.simple = (a < b) ? a : b;
            qalu_pkg::K_MAX:  n_ctl.simple = (a > b) ? a : b;
            qalu_pkg::K_INC:  n_ctl.simple = a + 32'sd1;
            qalu_pkg::K_DEC:  n_ctl.simple = a - 32'sd1;
            qalu_pkg::K_FROM: n_ctl.simple = a <<< FRAC_BITS;
            qalu_pkg::K_TOI:  n_ctl.simple = a >>> FRAC_BITS;
            default:          n_ctl.simple = '0;
        endcase
    end

    qalu_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk (i_clk),
        .i_a   (i_in.operand_a),
        .i_b   (i_in.operand_b),
        .o_p   (mul_p)
    );

    qalu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (n_ctl),
        .i_a     (i_in.operand_a),
        .i_b     (i_in.operand_b),
        .o_ctl   (div_ctl),
        .o_q     (div_q)
    );

    // Delay the product to line up with the divider output.
    always_ff @(posedge i_clk) begin
        r_mdly[0] <= mul_p;
        for (int i = 1; i < DLY; i++) begin
            r_mdly[i] <= r_mdly[i-1];
        end
    end

    // Pick the result for this item's kind.
    always_comb begin
        unique case (div_ctl.kind)
            qalu_pkg::K_MUL: n_res = r_mdly[DLY-1];
            qalu_pkg::K_DIV: n_res = div_ctl.dz ? 32'd0 : div_q;
            default:         n_res = div_ctl.simple;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= div_ctl.vld;
        end
        r_out.result      <= n_res;
        r_out.a_less      <= div_ctl.lt;
        r_out.a_equal     <= div_ctl.eq;
        r_out.a_greater   <= div_ctl.gt;
        r_out.div_by_zero <= div_ctl.dz;
    end

    assign o_done = r_done;
    assign o_out  = r_out;
endmodule

// ===== dv/q24_8_alu_checker.sv =====
`timescale 1ns / 1ps

// Watches the issue and result channels of the ALU, predicts each result
// and compares it field by field with what the block returns.
module q24_8_alu_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_busy,
    input  qalu_pkg::t_in  i_in,
    input  logic           i_done,
    input  qalu_pkg::t_out i_out,
    output int             o_fail_count,
    output int             o_pending,
    output int             o_result_count
);
    localparam int FRAC = qalu_pkg::FRAC_BITS_DEF;

    qalu_pkg::t_out expected_results[$];
    int   mismatch_count = 0;
    int   orphan_count = 0;
    int   result_count = 0;
    int   pending_count = 0;

    // Compute the ALU result for one item.
    function automatic qalu_pkg::t_out alu_predict(qalu_pkg::t_in item);
        qalu_pkg::t_out      r;
        logic signed [63:0]  a64;
        logic signed [63:0]  b64;
        logic signed [63:0]  wide;
        a64 = item.operand_a;
        b64 = item.operand_b;
        r = '0;
        case (item.kind)
            qalu_pkg::K_ADD:  r.result = item.operand_a + item.operand_b;
            qalu_pkg::K_SUB:  r.result = item.operand_a - item.operand_b;
            qalu_pkg::K_MUL: begin
                // SystemVerilog signed division truncates toward zero.
                wide = (a64 * b64) / (64'sd1 <<< FRAC);
                r.result = wide[31:0];
            end
            qalu_pkg::K_DIV: begin
                if (item.operand_b == 0) begin
                    r.div_by_zero = 1'b1;
                end else begin
                    wide = (a64 <<< FRAC) / b64;
                    r.result = wide[31:0];
                end
            end
            qalu_pkg::K_MIN:  r.result = (a64 < b64) ? item.operand_a : item.operand_b;
            qalu_pkg::K_MAX:  r.result = (a64 > b64) ? item.operand_a : item.operand_b;
            qalu_pkg::K_INC:  r.result = item.operand_a + 32'sd1;
            qalu_pkg::K_DEC:  r.result = item.operand_a - 32'sd1;
            qalu_pkg::K_FROM: r.result = item.operand_a << FRAC;
            qalu_pkg::K_TOI:  r.result = item.operand_a >>> FRAC;
            default: r.result = '0;
        endcase
        r.a_less    = a64 < b64;
        r.a_equal   = a64 == b64;
        r.a_greater = a64 > b64;
        return r;
    endfunction

    // Record expectations for accepted items and check each result.
    always @(posedge i_clk) begin
        qalu_pkg::t_out want;
        if (i_rst_n) begin
            if (i_start && !i_busy) begin
                expected_results.push_back(alu_predict(i_in));
            end
            if (i_done) begin
                result_count = result_count + 1;
                if (expected_results.size() == 0) begin
                    orphan_count = orphan_count + 1;
                    $display("ERROR: result %h with no item outstanding", i_out);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out !== want) begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= 10) begin
                            $display("ERROR: mismatch exp res=%h lt=%b eq=%b gt=%b dz=%b",
                                     want.result, want.a_less, want.a_equal,
                                     want.a_greater, want.div_by_zero);
                            $display("       got      res=%h lt=%b eq=%b gt=%b dz=%b",
                                     i_out.result, i_out.a_less, i_out.a_equal,
                                     i_out.a_greater, i_out.div_by_zero);
                        end
                    end
                end
            end
            pending_count = expected_results.size();
        end
    end

    assign o_result_count = result_count;
    assign o_pending      = pending_count;
    assign o_fail_count   = mismatch_count + orphan_count + pending_count;
endmodule

// ===== dv/q24_8_fixed_point_alu_tb.sv =====
`timescale 1ns / 1ps

module q24_8_fixed_point_alu_tb;
    localparam int LATENCY     = qalu_pkg::FRAC_BITS_DEF + 35;
    localparam int RANDOM_ITEMS = 550;
    localparam int CYCLE_LIMIT = 200000;

    logic  clk;
    logic  rst_n;
    logic  start;
    qalu_pkg::t_in   alu_in;
    logic  busy;
    logic  done;
    qalu_pkg::t_out  alu_out;
    int    fail_count;
    int    pending;
    int    result_count;
    int    cycle_count = 0;
    int    idle_pct;

    q24_8_fixed_point_alu u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_start (start),
        .i_in    (alu_in),
        .o_busy  (busy),
        .o_done  (done),
        .o_out   (alu_out)
    );

    q24_8_alu_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_in           (alu_in),
        .i_done         (done),
        .i_out          (alu_out),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    // Clock.
    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Watchdog on total run length.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Pick a random operand, weighted toward edge values.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($urandom_range(0, 3)) - 32'd1;
            3: return 32'($urandom_range(0, 2047)) - 32'd1024;
            4: return 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom();
        endcase
    endfunction

    // Issue one item, with an optional random gap before it.
    task automatic issue_item(logic [3:0] kind, logic [31:0] op_a, logic [31:0] op_b);
        while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        alu_in.kind <= kind;
        alu_in.operand_a <= op_a;
        alu_in.operand_b <= op_b;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    initial begin
        logic [3:0] k;
        logic [31:0] x;
        logic [31:0] y;
        idle_pct = 0;
        start = 1'b0;
        alu_in = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: every kind, field extremes, divide by zero, unused kinds.
        for (int i = 0; i <= int'(qalu_pkg::K_TOI); i++) begin
            issue_item(4'(i), 32'h8000_0000, 32'h7fff_ffff);
        end
        issue_item(qalu_pkg::K_DIV, 32'h0000_0100, 32'h0000_0000);
        issue_item(qalu_pkg::K_DIV, 32'h8000_0000, 32'hffff_ffff);
        issue_item(qalu_pkg::K_MUL, 32'h8000_0000, 32'h8000_0000);
        issue_item(qalu_pkg::K_MUL, 32'hffff_ff01, 32'h0000_0001);
        issue_item(qalu_pkg::K_TOI, 32'hffff_ff01, 32'h0000_0000);
        issue_item(qalu_pkg::K_INC, 32'h7fff_ffff, 32'h7fff_ffff);
        issue_item(qalu_pkg::K_DEC, 32'h8000_0000, 32'h8000_0000);
        issue_item(qalu_pkg::K_FROM, 32'hffff_ffff, 32'h0000_0001);
        issue_item(4'd10, 32'h1234_5678, 32'h1234_5678);
        issue_item(4'd15, 32'h0000_0001, 32'hffff_ffff);
        issue_item(qalu_pkg::K_MIN, 32'h0000_0005, 32'h0000_0005);
        issue_item(qalu_pkg::K_MAX, 32'h7fff_ffff, 32'h8000_0000);

        // Random items in three idling phases.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 0) idle_pct = 33;
            else if (i == RANDOM_ITEMS / 3) idle_pct = 73;
            else if (i == 2 * RANDOM_ITEMS / 3) idle_pct = 0;
            // Mostly valid kinds, an occasional unused one.
            k = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                             : 4'($urandom_range(0, 9));
            x = pick_operand();
            y = ($urandom_range(0, 9) == 0) ? x : pick_operand();
            if (k == qalu_pkg::K_DIV && $urandom_range(0, 9) == 0) y = '0;
            issue_item(k, x, y);
        end
        start <= 1'b0;

        // Drain, then allow the pipeline to settle.
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);

        $display("Ran %0d results over all ten kinds, unused kinds and divide by zero,",
                 result_count);
        $display("with sender idling at 33, 73 and 0 percent.");
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
